[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the stepper ramp sequencer RTL; they collapse
// to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define SRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SRS_ASSERT(label, clk, rst, prop, msg)
`define SRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[hdl/srs_pkg.sv]
// ----------------------------------------------------------------------------
// srs_pkg
// Widths, register indexes, reset values and word layouts of the stepper
// ramp sequencer.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int unsigned PatW      = 6;
   localparam int unsigned DelayW    = 8;
   localparam int unsigned RampW     = 8;
   localparam int unsigned PosW      = 10;
   localparam int unsigned CountW    = 16;
   localparam int unsigned CoilW     = 2;
   localparam int unsigned CsrIdxW   = 3;
   localparam int unsigned CsrDataW  = 10;
   localparam int unsigned ReqDataW  = 24;
   localparam int unsigned RspDataW  = 24;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_PATTERN_A    = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_PATTERN_B    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_PATTERN_C    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_PATTERN_D    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_START_DELAY  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_RAMP_STEPS   = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_POSITION_TOP = 3'd6;

   // register reset values
   localparam logic [PatW-1:0]   PATTERN_A_RST    = 6'h36;
   localparam logic [PatW-1:0]   PATTERN_B_RST    = 6'h2e;
   localparam logic [PatW-1:0]   PATTERN_C_RST    = 6'h2d;
   localparam logic [PatW-1:0]   PATTERN_D_RST    = 6'h35;
   localparam logic [DelayW-1:0] START_DELAY_RST  = 8'd20;
   localparam logic [RampW-1:0]  RAMP_STEPS_RST   = 8'd13;
   localparam logic [PosW-1:0]   POSITION_TOP_RST = 10'd200;

   // input word, tdata bits from the low end
   typedef struct packed {
      logic [CountW-1:0] move_count;
      logic              reverse;
   } req_word_type;

   // result word, tdata bits from the low end
   typedef struct packed {
      logic            refused;
      logic            busy_res;
      logic [PosW-1:0] position;
      logic [PatW-1:0] coil_pattern;
   } rsp_word_type;

   localparam int unsigned ReqPadW = ReqDataW - $bits(req_word_type);
   localparam int unsigned RspPadW = RspDataW - $bits(rsp_word_type);

endpackage

[hdl/stepper_ramp_sequencer.sv]
// ----------------------------------------------------------------------------
// stepper_ramp_sequencer
// Full-step stepper sequencer with a trapezoidal delay ramp, driven by
// millisecond tick words and move command words.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                                   tuser
//  req_     in         reverse, move_count                     func
//  rsp_     out        coil_pattern, position, busy, refused   -
//  csr_     in         write data, index 0..6                  -
//
//  one word per cycle sustained while rsp_ is not stalled; an accepted word
//  goes into the input register, and its result is then loaded into the
//  result register and presented on rsp_
//  the whole state update is one pass of counter logic between them
//  a stalled rsp_ holds the result register and then the input register
//  reset clears the valid flags and sequencer state and loads the register defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_ramp_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srs_pkg::ReqDataW-1:0]   req_tdata,   // reverse, move_count[15:0], zeros
   input  logic                           req_tuser,   // func
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [srs_pkg::RspDataW-1:0]   rsp_tdata,   // coil_pattern[5:0], position[9:0],
                                                       // busy_res, refused, zeros
   input  logic                           csr_we,
   input  logic [srs_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [srs_pkg::CsrDataW-1:0]   csr_wdata
);
   import srs_pkg::*;

   // configuration registers
   logic [PatW-1:0]   pattern_a_ff, pattern_b_ff, pattern_c_ff, pattern_d_ff;
   logic [DelayW-1:0] start_delay_ff;
   logic [RampW-1:0]  ramp_steps_ff;
   logic [PosW-1:0]   position_top_ff;

   // input register
   logic              in_valid_ff;
   logic              in_func_ff;
   req_word_type      in_word_ff;

   // sequencer state
   logic [CoilW-1:0]  coil_index_ff,     coil_index_in;
   logic [PosW-1:0]   rotor_position_ff, rotor_position_in;
   logic [DelayW-1:0] step_delay_ff,     step_delay_in;
   logic [CountW-1:0] step_index_ff,     step_index_in;
   logic [CountW-1:0] steps_total_ff,    steps_total_in;
   logic [DelayW-1:0] wait_ticks_ff,     wait_ticks_in;
   logic              moving_back_ff,    moving_back_in;
   logic              in_motion_ff,      in_motion_in;
   logic [PatW-1:0]   driven_pattern_ff, driven_pattern_in;
   logic              refused_in;

   // result register
   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              take;
   logic              dir_back;
   logic [CoilW-1:0]  coil_step;
   logic [PatW-1:0]   step_pattern;
   logic [DelayW-1:0] start_sat;
   logic [CountW-1:0] steps_left;
   logic              ramp_down, ramp_up;
   logic [DelayW+1:0] delay_raw;
   logic [DelayW-1:0] delay_sat;
   logic [PosW:0]     pos_inc;
   logic [PosW-1:0]   pos_next;
   logic [CountW-1:0] index_next;
   logic              move_done;
   logic              wait_end;
   logic [DelayW-1:0] wait_dec;

   // handshakes
   assign take       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || take;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RspPadW{1'b0}}, rsp_word_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_a_ff    <= PATTERN_A_RST;
         pattern_b_ff    <= PATTERN_B_RST;
         pattern_c_ff    <= PATTERN_C_RST;
         pattern_d_ff    <= PATTERN_D_RST;
         start_delay_ff  <= START_DELAY_RST;
         ramp_steps_ff   <= RAMP_STEPS_RST;
         position_top_ff <= POSITION_TOP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_A:    pattern_a_ff    <= csr_wdata[PatW-1:0];
            CSR_PATTERN_B:    pattern_b_ff    <= csr_wdata[PatW-1:0];
            CSR_PATTERN_C:    pattern_c_ff    <= csr_wdata[PatW-1:0];
            CSR_PATTERN_D:    pattern_d_ff    <= csr_wdata[PatW-1:0];
            CSR_START_DELAY:  start_delay_ff  <= csr_wdata[DelayW-1:0];
            CSR_RAMP_STEPS:   ramp_steps_ff   <= csr_wdata[RampW-1:0];
            CSR_POSITION_TOP: position_top_ff <= csr_wdata[PosW-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tuser;
         in_word_ff <= req_tdata[$bits(req_word_type)-1:0];
      end
   end

   // next coil phase, direction from the new command at a move start
   assign dir_back  = in_func_ff ? in_word_ff.reverse : moving_back_ff;
   assign coil_step = dir_back ? coil_index_ff - 2'd1 : coil_index_ff + 2'd1;

   always_comb begin
      unique case (coil_step)
         2'd0: step_pattern = pattern_a_ff;
         2'd1: step_pattern = pattern_b_ff;
         2'd2: step_pattern = pattern_c_ff;
         2'd3: step_pattern = pattern_d_ff;
      endcase
   end

   assign start_sat = (start_delay_ff == '0) ? DelayW'(1) : start_delay_ff;

   // ramp: down near the start, up near the end, clamp to 1..255
   assign steps_left = steps_total_ff - step_index_ff;
   assign ramp_down  = step_index_ff <= {{(CountW-RampW){1'b0}}, ramp_steps_ff};
   assign ramp_up    = steps_left <= {{(CountW-RampW){1'b0}}, ramp_steps_ff};
   assign delay_raw  = {2'b00, step_delay_ff} + {{(DelayW+1){1'b0}}, ramp_up}
                       - {{(DelayW+1){1'b0}}, ramp_down};
   assign delay_sat  = (delay_raw == '0)          ? DelayW'(1) :
                       (delay_raw[DelayW+1:DelayW] != 2'b00) ? {DelayW{1'b1}} :
                       delay_raw[DelayW-1:0];

   // position wrap between 0 and the top value
   assign pos_inc  = {1'b0, rotor_position_ff} + (PosW+1)'(1);
   assign pos_next = moving_back_ff ?
                     ((rotor_position_ff == '0) ? position_top_ff : rotor_position_ff - PosW'(1)) :
                     ((pos_inc > {1'b0, position_top_ff}) ? '0 : pos_inc[PosW-1:0]);

   assign index_next = step_index_ff + CountW'(1);
   assign move_done  = index_next >= steps_total_ff;
   assign wait_end   = wait_ticks_ff <= DelayW'(1);
   assign wait_dec   = (wait_ticks_ff == '0) ? '0 : wait_ticks_ff - DelayW'(1);

   always_comb begin
      coil_index_in     = coil_index_ff;
      rotor_position_in = rotor_position_ff;
      step_delay_in     = step_delay_ff;
      step_index_in     = step_index_ff;
      steps_total_in    = steps_total_ff;
      wait_ticks_in     = wait_ticks_ff;
      moving_back_in    = moving_back_ff;
      in_motion_in      = in_motion_ff;
      driven_pattern_in = driven_pattern_ff;
      refused_in        = 1'b0;
      if (in_func_ff) begin
         if (in_motion_ff) begin
            refused_in = 1'b1;
         end else begin
            steps_total_in = in_word_ff.move_count;
            step_index_in  = '0;
            step_delay_in  = start_sat;
            moving_back_in = in_word_ff.reverse;
            if (in_word_ff.move_count != '0) begin
               coil_index_in     = coil_step;
               driven_pattern_in = step_pattern;
               wait_ticks_in     = start_sat;
               in_motion_in      = 1'b1;
            end
         end
      end else if (in_motion_ff) begin
         wait_ticks_in = wait_dec;
         if (wait_end) begin
            step_delay_in     = delay_sat;
            rotor_position_in = pos_next;
            step_index_in     = index_next;
            if (move_done) begin
               in_motion_in = 1'b0;
            end else begin
               coil_index_in     = coil_step;
               driven_pattern_in = step_pattern;
               wait_ticks_in     = delay_sat;
            end
         end
      end
   end

   always_comb begin
      rsp_word_in.coil_pattern = driven_pattern_in;
      rsp_word_in.position     = rotor_position_in;
      rsp_word_in.busy_res     = in_motion_in;
      rsp_word_in.refused      = refused_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coil_index_ff     <= '0;
         rotor_position_ff <= '0;
         step_delay_ff     <= '0;
         step_index_ff     <= '0;
         steps_total_ff    <= '0;
         wait_ticks_ff     <= '0;
         moving_back_ff    <= 1'b0;
         in_motion_ff      <= 1'b0;
         driven_pattern_ff <= '0;
      end else if (take) begin
         coil_index_ff     <= coil_index_in;
         rotor_position_ff <= rotor_position_in;
         step_delay_ff     <= step_delay_in;
         step_index_ff     <= step_index_in;
         steps_total_ff    <= steps_total_in;
         wait_ticks_ff     <= wait_ticks_in;
         moving_back_ff    <= moving_back_in;
         in_motion_ff      <= in_motion_in;
         driven_pattern_ff <= driven_pattern_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   `SRS_ASSERT(a_refused_busy, clock, reset, !(rsp_valid_ff && rsp_word_ff.refused) || rsp_word_ff.busy_res, "refused word without busy")
   `SRS_ASSERT(a_index_in_range, clock, reset, !in_motion_ff || (step_index_ff < steps_total_ff), "step index past move length")
   `SRS_ASSERT(a_wait_loaded, clock, reset, !in_motion_ff || (wait_ticks_ff != '0), "moving with empty wait count")
   `SRS_ASSERT(a_delay_floor, clock, reset, !in_motion_ff || (step_delay_ff != '0), "moving with zero step delay")
   `SRS_ASSERT_NEXT(a_move_starts, clock, reset, take && in_func_ff && !in_motion_ff && (in_word_ff.move_count != '0), in_motion_ff, "move from idle did not start")

endmodule
